// ===== rtl/core/gravity_body_update_assert.svh =====
// Assertion macros for the gravity body update block.
`ifndef GRAVITY_BODY_UPDATE_ASSERT_SVH
`define GRAVITY_BODY_UPDATE_ASSERT_SVH
`ifndef SYNTHESIS
`define GBU_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gravity_body_update: check failed");
`define GBU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gravity_body_update: check failed");
`else
`define GBU_ASSERT(lbl, ante, cons)
`define GBU_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/gbu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gravity body update block.
package gbu_pkg;
  localparam int ACC_WIDTH = 48;
  localparam int TICK_DIV  = 10000;

  typedef enum logic [1:0] {
    ACT_INTERACT = 2'd0,
    ACT_FINISH   = 2'd1,
    ACT_POSITION = 2'd2,
    ACT_LOAD     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    OP_MUL  = 3'b001,
    OP_DIV  = 3'b010,
    OP_SQRT = 3'b100
  } op_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } unit_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;
endpackage

// ===== rtl/core/gbu_serial.sv =====
`timescale 1ns / 1ps
// Bit-serial multiply, divide and square root unit, one result bit per cycle.
module gbu_serial import gbu_pkg::*; #(
  parameter int UW   = 80,
  parameter int MULW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  unit_req_t     req,
  input  logic [UW-1:0] a,
  input  logic [UW-1:0] b,
  output unit_stat_t    stat,
  output logic [UW-1:0] res
);
  localparam int RW  = UW + 2;
  localparam int CNW = $clog2(UW + 1);

  logic           busy;
  logic           done;
  op_t            op;
  logic [CNW-1:0] cnt;
  logic [RW-1:0]  rem;
  logic [UW-1:0]  x;
  logic [UW-1:0]  y;
  logic [UW-1:0]  q;
  logic [RW-1:0]  shifted;
  logic [RW-1:0]  trial;
  logic [RW-1:0]  diff;
  logic           take;

  always_comb begin
    shifted = '0;
    trial   = '0;
    case (op)
      OP_DIV: begin
        shifted = {rem[RW-2:0], x[UW-1]};
        trial   = {2'b00, y};
      end
      OP_SQRT: begin
        shifted = {rem[RW-3:0], x[UW-1:UW-2]};
        trial   = {q, 2'b01};
      end
      default: ;
    endcase
    diff = shifted - trial;
    take = (shifted >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        unique case (req.op)
          OP_MUL:  cnt <= CNW'(MULW);
          OP_DIV:  cnt <= CNW'(UW);
          OP_SQRT: cnt <= CNW'(UW / 2);
          default: cnt <= CNW'(UW);
        endcase
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      op  <= req.op;
      x   <= a;
      y   <= b;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      unique case (op)
        OP_MUL: begin
          if (y[0]) begin
            rem <= rem + {2'b00, x};
          end
          x <= x << 1;
          y <= y >> 1;
        end
        OP_DIV: begin
          rem <= take ? diff : shifted;
          q   <= {q[UW-2:0], take};
          x   <= x << 1;
        end
        OP_SQRT: begin
          rem <= take ? diff : shifted;
          q   <= {q[UW-2:0], take};
          x   <= x << 2;
        end
        default: ;
      endcase
    end
  end

  assign res       = (op == OP_MUL) ? rem[UW-1:0] : q;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// ===== rtl/core/gravity_body_update.sv =====
`timescale 1ns / 1ps
// Top level: one body of an n-body step with merge, in fixed point.
//
//  channel | dir | fields (lowest bit up)
//  s_*     | in  | tdata: frame_time, body_x, body_y, body_vx, body_vy, body_mass
//          |     | tuser: action, other_removed
//  m_*     | out | tdata: out_x, out_y, out_vx, out_vy, out_mass; tuser: merged
//
// One item at a time through a shared bit-serial unit that does every multiply,
// divide and square root step (MW = max(COORD_WIDTH,32), UW = 80 at defaults).
// Reset is synchronous; the next item is taken while a result waits on m_*, and
// its own result is held back until the waiting one is accepted.
`include "gravity_body_update_assert.svh"
module gravity_body_update import gbu_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // frame_time, body_x, body_y, body_vx, body_vy, body_mass
  input  logic [2:0]   s_tuser,  // action, other_removed
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,  // out_x, out_y, out_vx, out_vy, out_mass
  output logic         m_tuser   // merged
);
  localparam int MW = (COORD_WIDTH > 32) ? COORD_WIDTH : 32;
  localparam int KW = (MW > ACC_WIDTH) ? MW : ACC_WIDTH;
  localparam int SW = 2 * MW + 1;
  localparam int U0 = (SW > KW + 32) ? SW : KW + 32;
  localparam int U1 = (U0 > 32 + 2 * FRAC_BITS) ? U0 : 32 + 2 * FRAC_BITS;
  localparam int UW = U1 + (U1 % 2);
  localparam int EW = UW + 2;
  localparam logic [SW-1:0] ONE2 = SW'(1) << (2 * FRAC_BITS);

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_DIFF  = 15'b000000000000010,
    S_SQX   = 15'b000000000000100,
    S_SQY   = 15'b000000000001000,
    S_TEST  = 15'b000000000010000,
    S_MMUL  = 15'b000000000100000,
    S_MDIV  = 15'b000000001000000,
    S_ROOT  = 15'b000000010000000,
    S_TM    = 15'b000000100000000,
    S_AMUL  = 15'b000001000000000,
    S_ADIV  = 15'b000010000000000,
    S_IPREP = 15'b000100000000000,
    S_IMUL  = 15'b001000000000000,
    S_IDIV  = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  state_t                         state;
  logic                           lane;
  logic                           pending;
  action_t                        act;
  logic [31:0]                    ftime;
  logic signed [31:0]             bx;
  logic signed [31:0]             by;
  logic signed [31:0]             bvx;
  logic signed [31:0]             bvy;
  logic [31:0]                    bm;
  logic signed [COORD_WIDTH-1:0]  pos_x;
  logic signed [COORD_WIDTH-1:0]  pos_y;
  logic signed [COORD_WIDTH-1:0]  vel_x;
  logic signed [COORD_WIDTH-1:0]  vel_y;
  logic signed [ACC_WIDTH-1:0]    acc_x;
  logic signed [ACC_WIDTH-1:0]    acc_y;
  logic [31:0]                    own_mass;
  logic [31:0]                    last_vel_time;
  logic [31:0]                    last_pos_time;
  logic [KW-1:0]                  mx;
  logic [KW-1:0]                  my;
  logic                           nx;
  logic                           ny;
  logic [SW-1:0]                  ssum;
  logic [UW-1:0]                  root;
  logic [31:0]                    tm;
  logic [UW-1:0]                  work;
  logic [32:0]                    total;
  logic                           merged_r;

  unit_req_t                      req;
  unit_stat_t                     stat;
  logic [UW-1:0]                  ua;
  logic [UW-1:0]                  ub;
  logic [UW-1:0]                  res;
  logic                           arith;

  logic signed [EW-1:0]           dx_w;
  logic signed [EW-1:0]           dy_w;
  logic signed [EW-1:0]           ex_w;
  logic signed [EW-1:0]           ey_w;
  logic signed [EW-1:0]           src_x_w;
  logic signed [EW-1:0]           src_y_w;
  logic [KW-1:0]                  mag;
  logic                           sgn;
  logic [31:0]                    dt;
  logic [32:0]                    tot;

  function automatic logic signed [EW-1:0] sat_to(input logic signed [EW-1:0] v, input int w);
    logic signed [EW-1:0] hi;
    logic signed [EW-1:0] lo;
    hi = signed'((EW'(1) << (w - 1)) - EW'(1));
    lo = -hi - signed'(EW'(1));
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic logic signed [EW-1:0] add_sat(input logic signed [EW-1:0] base,
                                                   input logic neg,
                                                   input logic [UW-1:0] magv,
                                                   input int w);
    logic signed [EW-1:0] m;
    m = signed'(EW'(magv));
    return sat_to(neg ? base - m : base + m, w);
  endfunction

  function automatic logic [KW-1:0] mag_of(input logic signed [EW-1:0] v);
    logic [EW-1:0] m;
    m = v[EW-1] ? -v : v;
    return m[KW-1:0];
  endfunction

  assign s_tready = (state == S_IDLE);

  assign dx_w    = EW'(bx) - EW'(pos_x);
  assign dy_w    = EW'(by) - EW'(pos_y);
  assign ex_w    = EW'(bvx) - EW'(vel_x);
  assign ey_w    = EW'(bvy) - EW'(vel_y);
  assign src_x_w = (act == ACT_FINISH) ? EW'(acc_x) : EW'(vel_x);
  assign src_y_w = (act == ACT_FINISH) ? EW'(acc_y) : EW'(vel_y);
  assign mag     = lane ? my : mx;
  assign sgn     = lane ? ny : nx;
  assign dt      = ftime - ((act == ACT_FINISH) ? last_vel_time : last_pos_time);
  assign tot     = {1'b0, own_mass} + {1'b0, bm};

  always_comb begin
    req.op = OP_MUL;
    ua     = '0;
    ub     = '0;
    arith  = 1'b1;
    unique case (state)
      S_SQX: begin
        ua = UW'(mx);
        ub = UW'(mx);
      end
      S_SQY: begin
        ua = UW'(my);
        ub = UW'(my);
      end
      S_MMUL: begin
        ua = UW'(mag);
        ub = UW'(bm);
      end
      S_MDIV: begin
        req.op = OP_DIV;
        ua     = work;
        ub     = UW'(total);
      end
      S_ROOT: begin
        req.op = OP_SQRT;
        ua     = UW'(ssum);
      end
      S_TM: begin
        req.op = OP_DIV;
        ua     = UW'(bm) << (2 * FRAC_BITS);
        ub     = UW'(ssum);
      end
      S_AMUL: begin
        ua = UW'(mag);
        ub = UW'(tm);
      end
      S_ADIV: begin
        req.op = OP_DIV;
        ua     = work;
        ub     = root;
      end
      S_IMUL: begin
        ua = UW'(mag);
        ub = UW'(dt);
      end
      S_IDIV: begin
        req.op = OP_DIV;
        ua     = work;
        ub     = UW'(TICK_DIV);
      end
      default: arith = 1'b0;
    endcase
    req.start = arith && !pending && !stat.done;
  end

  gbu_serial #(
    .UW   (UW),
    .MULW (MW)
  ) u_serial (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (ua),
    .b    (ub),
    .stat (stat),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      lane          <= 1'b0;
      pending       <= 1'b0;
      m_tvalid      <= 1'b0;
      pos_x         <= '0;
      pos_y         <= '0;
      vel_x         <= '0;
      vel_y         <= '0;
      acc_x         <= '0;
      acc_y         <= '0;
      own_mass      <= '0;
      last_vel_time <= '0;
      last_pos_time <= '0;
    end else begin
      if (req.start) begin
        pending <= 1'b1;
      end
      if (stat.done) begin
        pending <= 1'b0;
      end
      if (m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act      <= action_t'(s_tuser[1:0]);
            ftime    <= s_tdata[31:0];
            bx       <= signed'(s_tdata[63:32]);
            by       <= signed'(s_tdata[95:64]);
            bvx      <= signed'(s_tdata[127:96]);
            bvy      <= signed'(s_tdata[159:128]);
            bm       <= s_tdata[191:160];
            merged_r <= 1'b0;
            lane     <= 1'b0;
            case (action_t'(s_tuser[1:0])) inside
              ACT_INTERACT: state <= s_tuser[2] ? S_OUT : S_DIFF;
              ACT_FINISH, ACT_POSITION: state <= S_IPREP;
              default: begin
                pos_x <= COORD_WIDTH'(sat_to(EW'(signed'(s_tdata[63:32])), COORD_WIDTH));
                pos_y <= COORD_WIDTH'(sat_to(EW'(signed'(s_tdata[95:64])), COORD_WIDTH));
                vel_x <= COORD_WIDTH'(sat_to(EW'(signed'(s_tdata[127:96])), COORD_WIDTH));
                vel_y <= COORD_WIDTH'(sat_to(EW'(signed'(s_tdata[159:128])), COORD_WIDTH));
                own_mass      <= s_tdata[191:160];
                acc_x         <= '0;
                acc_y         <= '0;
                last_vel_time <= s_tdata[31:0];
                last_pos_time <= s_tdata[31:0];
                state         <= S_OUT;
              end
            endcase
          end
        end
        S_DIFF: begin
          mx    <= mag_of(dx_w);
          nx    <= dx_w[EW-1];
          my    <= mag_of(dy_w);
          ny    <= dy_w[EW-1];
          state <= S_SQX;
        end
        S_SQX: begin
          if (stat.done) begin
            work  <= res;
            state <= S_SQY;
          end
        end
        S_SQY: begin
          if (stat.done) begin
            ssum  <= work[SW-1:0] + res[SW-1:0];
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (ssum <= ONE2) begin
            merged_r <= 1'b1;
            own_mass <= tot[32] ? 32'hFFFF_FFFF : tot[31:0];
            total    <= tot;
            mx       <= mag_of(ex_w);
            nx       <= ex_w[EW-1];
            my       <= mag_of(ey_w);
            ny       <= ey_w[EW-1];
            if (tot == '0) begin
              vel_x <= '0;
              vel_y <= '0;
              state <= S_OUT;
            end else begin
              state <= S_MMUL;
            end
          end else begin
            state <= S_ROOT;
          end
        end
        S_MMUL: begin
          if (stat.done) begin
            work  <= res;
            state <= S_MDIV;
          end
        end
        S_MDIV: begin
          if (stat.done) begin
            if (lane) begin
              vel_y <= COORD_WIDTH'(add_sat(EW'(vel_y), sgn, res, COORD_WIDTH));
              state <= S_OUT;
            end else begin
              vel_x <= COORD_WIDTH'(add_sat(EW'(vel_x), sgn, res, COORD_WIDTH));
              lane  <= 1'b1;
              state <= S_MMUL;
            end
          end
        end
        S_ROOT: begin
          if (stat.done) begin
            root  <= res;
            state <= S_TM;
          end
        end
        S_TM: begin
          if (stat.done) begin
            tm    <= res[31:0];
            state <= S_AMUL;
          end
        end
        S_AMUL: begin
          if (stat.done) begin
            work  <= res;
            state <= S_ADIV;
          end
        end
        S_ADIV: begin
          if (stat.done) begin
            if (lane) begin
              acc_y <= ACC_WIDTH'(add_sat(EW'(acc_y), sgn, res, ACC_WIDTH));
              state <= S_OUT;
            end else begin
              acc_x <= ACC_WIDTH'(add_sat(EW'(acc_x), sgn, res, ACC_WIDTH));
              lane  <= 1'b1;
              state <= S_AMUL;
            end
          end
        end
        S_IPREP: begin
          mx    <= mag_of(src_x_w);
          nx    <= src_x_w[EW-1];
          my    <= mag_of(src_y_w);
          ny    <= src_y_w[EW-1];
          state <= S_IMUL;
        end
        S_IMUL: begin
          if (stat.done) begin
            work  <= res;
            state <= S_IDIV;
          end
        end
        S_IDIV: begin
          if (stat.done) begin
            if (act == ACT_FINISH) begin
              if (lane) begin
                vel_y <= COORD_WIDTH'(add_sat(EW'(vel_y), sgn, res, COORD_WIDTH));
              end else begin
                vel_x <= COORD_WIDTH'(add_sat(EW'(vel_x), sgn, res, COORD_WIDTH));
              end
            end else begin
              if (lane) begin
                pos_y <= COORD_WIDTH'(add_sat(EW'(pos_y), sgn, res, COORD_WIDTH));
              end else begin
                pos_x <= COORD_WIDTH'(add_sat(EW'(pos_x), sgn, res, COORD_WIDTH));
              end
            end
            if (lane) begin
              if (act == ACT_FINISH) begin
                last_vel_time <= ftime;
              end else begin
                last_pos_time <= ftime;
                acc_x         <= '0;
                acc_y         <= '0;
              end
              state <= S_OUT;
            end else begin
              lane  <= 1'b1;
              state <= S_IMUL;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= merged_r;
            m_tdata  <= {own_mass,
                         32'(sat_to(EW'(vel_y), 32)),
                         32'(sat_to(EW'(vel_x), 32)),
                         32'(sat_to(EW'(pos_y), 32)),
                         32'(sat_to(EW'(pos_x), 32))};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `GBU_ASSERT(a_no_start_busy, req.start, !stat.busy)
  `GBU_ASSERT(a_done_pending, stat.done, pending)
  `GBU_ASSERT(a_idle_clear, state == S_IDLE, !pending)
  `GBU_ASSERT_NEXT(a_far_root, state == S_TEST && ssum > ONE2, state == S_ROOT)
endmodule

// ===== verif/gravity_body_update_check.sv =====
`timescale 1ns / 1ps
// Checker: watches both channels of the gravity body update block and compares its results.
module gravity_body_update_check import gbu_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [191:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [159:0] m_tdata,
  input  logic         m_tuser,
  output int           errors,
  output int           pending
);

  typedef struct {
    logic        merged;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] vx;
    logic [31:0] vy;
    logic [31:0] mass;
  } body_state_t;

  body_state_t states_due[$];

  longint      px, py, vx, vy, ax, ay;
  logic [31:0] mass, t_vel, t_pos;

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (64'sd1 <<< (w - 1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic [127:0] mag(longint v);
    logic [127:0] m;
    m = v < 0 ? 128'(-v) : 128'(v);
    return m;
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] s);
    logic [127:0] r, c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r;
  endfunction

  function automatic longint drift(longint val, logic [31:0] dt);
    logic [127:0] p, d;
    d = {96'd0, dt};
    p = mag(val) * d / 128'd10000;
    if (p > (128'd1 << 50)) p = 128'd1 << 50;
    return val < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  task automatic absorb_or_pull(longint bx, longint by, longint bvx, longint bvy,
                                logic [31:0] bm, output logic merged);
    longint       dx, dy, ex, ey;
    logic [127:0] mx, my, s, total, q, tm, a;
    dx = bx - px;
    dy = by - py;
    mx = mag(dx);
    my = mag(dy);
    s = mx * mx + my * my;
    merged = 1'b0;
    if (s <= (128'd1 << 32)) begin
      merged = 1'b1;
      total = {96'd0, mass} + {96'd0, bm};
      if (total == 0) begin
        vx = 0;
        vy = 0;
      end else begin
        ex = bvx - vx;
        ey = bvy - vy;
        a = mag(ex) * {96'd0, bm} / total;
        vx = clip(vx + (ex < 0 ? -longint'(a[63:0]) : longint'(a[63:0])), 32);
        a = mag(ey) * {96'd0, bm} / total;
        vy = clip(vy + (ey < 0 ? -longint'(a[63:0]) : longint'(a[63:0])), 32);
      end
      mass = total > 128'hFFFF_FFFF ? 32'hFFFF_FFFF : total[31:0];
    end else begin
      q = root_floor(s);
      tm = ({96'd0, bm} << 32) / s;
      a = mx * tm / q;
      if (a > (128'd1 << 48)) a = 128'd1 << 48;
      ax = clip(ax + (dx < 0 ? -longint'(a[63:0]) : longint'(a[63:0])), 48);
      a = my * tm / q;
      if (a > (128'd1 << 48)) a = 128'd1 << 48;
      ay = clip(ay + (dy < 0 ? -longint'(a[63:0]) : longint'(a[63:0])), 48);
    end
  endtask

  task automatic advance_body(logic [191:0] d, logic [2:0] u);
    action_t     act;
    logic [31:0] t, bm;
    longint      bx, by, bvx, bvy;
    logic        merged;
    body_state_t e;
    act = action_t'(u[1:0]);
    t = d[31:0];
    bx = longint'($signed(d[63:32]));
    by = longint'($signed(d[95:64]));
    bvx = longint'($signed(d[127:96]));
    bvy = longint'($signed(d[159:128]));
    bm = d[191:160];
    merged = 1'b0;
    case (act)
      ACT_INTERACT: begin
        if (!u[2]) absorb_or_pull(bx, by, bvx, bvy, bm, merged);
      end
      ACT_FINISH: begin
        vx = clip(vx + drift(ax, t - t_vel), 32);
        vy = clip(vy + drift(ay, t - t_vel), 32);
        t_vel = t;
      end
      ACT_POSITION: begin
        ax = 0;
        ay = 0;
        px = clip(px + drift(vx, t - t_pos), 32);
        py = clip(py + drift(vy, t - t_pos), 32);
        t_pos = t;
      end
      default: begin
        px = bx;
        py = by;
        vx = bvx;
        vy = bvy;
        mass = bm;
        ax = 0;
        ay = 0;
        t_vel = t;
        t_pos = t;
      end
    endcase
    e.merged = merged;
    e.x = px[31:0];
    e.y = py[31:0];
    e.vx = vx[31:0];
    e.vy = vy[31:0];
    e.mass = mass;
    states_due.push_back(e);
  endtask

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      errors++;
    end
  endtask

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    body_state_t e;
    if (rst) begin
      px = 0; py = 0; vx = 0; vy = 0; ax = 0; ay = 0;
      mass = '0; t_vel = '0; t_pos = '0;
      states_due.delete();
    end else begin
      if (s_tvalid && s_tready) advance_body(s_tdata, s_tuser);
      if (m_tvalid && m_tready) begin
        if (states_due.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          e = states_due.pop_front();
          compare_field("merged", {31'd0, e.merged}, {31'd0, m_tuser});
          compare_field("out_x", e.x, m_tdata[31:0]);
          compare_field("out_y", e.y, m_tdata[63:32]);
          compare_field("out_vx", e.vx, m_tdata[95:64]);
          compare_field("out_vy", e.vy, m_tdata[127:96]);
          compare_field("out_mass", e.mass, m_tdata[159:128]);
        end
      end
    end
    pending = states_due.size();
  end

endmodule

// ===== verif/gravity_body_update_test.sv =====
`timescale 1ns / 1ps
// Testbench top: drives the gravity body update block and reports the verdict.
module gravity_body_update_test import gbu_pkg::*; ();

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [191:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [159:0] m_tdata;
  logic         m_tuser;
  int           errors;
  int           pending;
  int           sent;
  bit           quiet;
  logic [31:0]  now, home_x, home_y;

  gravity_body_update DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  gravity_body_update_check checker_i (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      m_tready <= 1'b1;
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;
      1: case ($urandom_range(0, 4))
           0: return 32'h0;
           1: return 32'h1;
           2: return 32'h7FFF_FFFF;
           3: return 32'h8000_0000;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom();
    endcase
  endfunction

  task automatic send(action_t act, logic [31:0] t, logic [31:0] bx, logic [31:0] by,
                      logic [31:0] bvx, logic [31:0] bvy, logic [31:0] bm, logic rem);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {bm, bvy, bvx, by, bx, t};
    s_tuser <= {rem, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
  endtask

  task automatic near_body(logic rem);
    send(ACT_INTERACT, $urandom(), home_x + $urandom_range(0, 32'h3_0000) - 32'h1_8000,
         home_y + $urandom_range(0, 32'h3_0000) - 32'h1_8000, pick32(), pick32(), pick32(), rem);
  endtask

  initial begin
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    sent = 0;
    quiet = 1'b0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(ACT_LOAD, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_INTERACT, 5, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0);
    send(ACT_LOAD, 100, 0, 0, 32'h1_0000, 32'hFFFF_0000, 32'h1_0000, 0);
    send(ACT_INTERACT, 7, 32'h8000, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send(ACT_INTERACT, 7, 0, 0, 32'h5_0000, 0, 32'h5_0000, 1);
    send(ACT_INTERACT, 7, 32'h1_0000, 0, 32'h2_0000, 0, 32'h1_0000, 0);
    send(ACT_INTERACT, 7, 32'h1_0001, 0, 32'h2_0000, 0, 32'h1_0000, 0);
    send(ACT_INTERACT, 7, 32'hA_0000, 0, 0, 0, 32'h5_0000, 0);
    send(ACT_INTERACT, 7, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0);
    send(ACT_FINISH, 20100, 0, 0, 0, 0, 0, 0);
    send(ACT_POSITION, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0);
    send(ACT_LOAD, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
         32'h8000_0000, 32'hFFFF_FFFF, 0);
    repeat (3) send(ACT_INTERACT, 1, 32'h8000_0001, 32'h7FFF_FFFF, 0, 0, 32'hFFFF_FFFF, 0);
    send(ACT_INTERACT, 1, 32'h7FFF_FFF0, 32'h8000_0010, 0, 0, 32'hFFFF_FFFF, 0);
    send(ACT_FINISH, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    send(ACT_POSITION, 0, 0, 0, 0, 0, 0, 0);
    send(ACT_INTERACT, 3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 32'h8765_4321,
         32'h0002_0000, 0);
    send(ACT_FINISH, 9, 0, 0, 0, 0, 0, 0);

    now = 32'd1000;
    while (sent < 870) begin
      if (sent > 760) quiet = 1'b1;
      if (sent > 400 && sent < 420) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        send(action_t'($urandom_range(0, 3)), $urandom(), pick32(), pick32(), pick32(),
             pick32(), pick32(), $urandom_range(0, 1));
      end else begin
        home_x = pick32();
        home_y = pick32();
        now = now + $urandom_range(0, 50000);
        send(ACT_LOAD, now, home_x, home_y, pick32(), pick32(), pick32(), 0);
        repeat ($urandom_range(1, 8)) begin
          case ($urandom_range(0, 6))
            0: near_body(1'b1);
            1, 2: near_body(1'b0);
            default: send(ACT_INTERACT, $urandom(), pick32(), pick32(), pick32(), pick32(),
                          pick32(), $urandom_range(0, 7) == 0);
          endcase
        end
        now = now + $urandom_range(0, 100000);
        send(ACT_FINISH, now, pick32(), pick32(), pick32(), pick32(), pick32(), 1'b0);
        now = now + $urandom_range(0, 100000);
        send(ACT_POSITION, now, pick32(), pick32(), pick32(), pick32(), pick32(), 1'b0);
      end
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/gbu_pkg.sv
rtl/core/gbu_serial.sv
rtl/core/gravity_body_update.sv
verif/gravity_body_update_check.sv
verif/gravity_body_update_test.sv
